[rtl/icp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types and constants for the bounded integer partition counter.
// ----------------------------------------------------------------------------
package icp_pkg;

    localparam int FIELD_W    = 7;
    localparam int WAYS_W     = 21;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [WAYS_W-1:0] WAYS_MAX = {WAYS_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_UPD,
        ST_DRAIN,
        ST_DONE
    } icp_state_t;

    // query handed from the front end to the table engine
    typedef struct packed {
        logic               start;
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] part;
    } icp_cmd_t;

    // answer from the table engine, held until acknowledged
    typedef struct packed {
        logic              done;
        logic [WAYS_W-1:0] ways;
    } icp_rsp_t;

endpackage

`default_nettype wire

[rtl/icp_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icp_table
// Work table of partial counts: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module icp_table
    import icp_pkg::*;
#(
    parameter int DEPTH = 65,
    parameter int AW    = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [WAYS_W-1:0] wdata,
    input  wire logic [AW-1:0]     ra_hi,
    input  wire logic [AW-1:0]     ra_lo,
    output logic      [WAYS_W-1:0] rd_hi,
    output logic      [WAYS_W-1:0] rd_lo
);

    logic [WAYS_W-1:0] mem [DEPTH];
    logic [WAYS_W-1:0] rd_hi_reg;
    logic [WAYS_W-1:0] rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_hi_reg <= mem[ra_hi];
        rd_lo_reg <= mem[ra_lo];
    end

    assign rd_hi = rd_hi_reg;
    assign rd_lo = rd_lo_reg;

endmodule

`default_nettype wire

[rtl/icp_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icp_engine
// Rebuilds the partial count table for one query: clears entries 0..total,
// then runs count[s] += count[s-k] for every part size k, one step a cycle.
// ----------------------------------------------------------------------------
module icp_engine
    import icp_pkg::*;
#(
    parameter int AW        = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire icp_cmd_t          cmd,
    input  wire logic              ack,
    output icp_rsp_t               rsp,
    output logic                   we,
    output logic      [AW-1:0]     waddr,
    output logic      [WAYS_W-1:0] wdata,
    output logic      [AW-1:0]     ra_hi,
    output logic      [AW-1:0]     ra_lo,
    input  wire logic [WAYS_W-1:0] rd_hi,
    input  wire logic [WAYS_W-1:0] rd_lo
);

    icp_state_t state_reg, state_next;
    logic [AW-1:0] s_reg, s_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] total_reg, total_next;
    logic [AW-1:0] part_reg, part_next;

    // read-side pipeline stage: the step whose operands arrive this cycle
    logic          p_vld_reg, p_vld_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic [AW-1:0] p_lo_addr_reg, p_lo_addr_next;

    // last write, forwarded to a read that sampled the table at the same edge
    logic              lw_vld_reg;
    logic [AW-1:0]     lw_addr_reg;
    logic [WAYS_W-1:0] lw_data_reg;

    logic [WAYS_W-1:0] op_hi;
    logic [WAYS_W-1:0] op_lo;
    logic [WAYS_W:0]   sum_wide;
    logic [WAYS_W-1:0] sum;

    always_comb
    begin
        op_hi    = (lw_vld_reg && (lw_addr_reg == p_addr_reg)) ? lw_data_reg : rd_hi;
        op_lo    = (lw_vld_reg && (lw_addr_reg == p_lo_addr_reg)) ? lw_data_reg : rd_lo;
        sum_wide = {1'b0, op_hi} + {1'b0, op_lo};
        sum      = sum_wide[WAYS_W] ? WAYS_MAX : sum_wide[WAYS_W-1:0];
    end

    // next state and counters
    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        part_next      = part_reg;
        p_vld_next     = 1'b0;
        p_addr_next    = s_reg;
        p_lo_addr_next = s_reg - k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_INIT;
                    s_next     = '0;
                    total_next = cmd.total[AW-1:0];
                    part_next  = cmd.part[AW-1:0];
                end
            end
            ST_INIT:
            begin
                if (s_reg == total_reg)
                begin
                    state_next = ST_UPD;
                    s_next     = AW'(1);
                    k_next     = AW'(1);
                end
                else
                begin
                    s_next = s_reg + AW'(1);
                end
            end
            ST_UPD:
            begin
                p_vld_next = 1'b1;
                if (s_reg == total_reg)
                begin
                    if (k_reg == part_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next = k_reg + AW'(1);
                        s_next = k_reg + AW'(1);
                    end
                end
                else
                begin
                    s_next = s_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table port and answer
    always_comb
    begin
        we       = 1'b0;
        waddr    = p_addr_reg;
        wdata    = sum;
        ra_hi    = s_reg;
        ra_lo    = s_reg - k_reg;
        rsp.done = 1'b0;
        rsp.ways = lw_data_reg;
        case (state_reg)
            ST_INIT:
            begin
                we    = 1'b1;
                waddr = s_reg;
                wdata = (s_reg == '0) ? WAYS_W'(1) : '0;
            end
            ST_UPD, ST_DRAIN:
            begin
                we = p_vld_reg;
            end
            ST_DONE:
            begin
                rsp.done = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            p_vld_reg  <= 1'b0;
            lw_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p_vld_reg  <= p_vld_next;
            lw_vld_reg <= we;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        k_reg         <= k_next;
        total_reg     <= total_next;
        part_reg      <= part_next;
        p_addr_reg    <= p_addr_next;
        p_lo_addr_reg <= p_lo_addr_next;
        if (we)
        begin
            lw_addr_reg <= waddr;
            lw_data_reg <= wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/integer_partition_count_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_partition_count_top
// Counts the partitions of total into parts no larger than largest_part.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: total and largest_part (above total it is
//   clipped to total). m_axis returns one result per request: ways, and in
//   tuser a bad_query flag for a zero total, a total above MAX_TOTAL, or a
//   zero part size with a total above one (ways is then zero).
//   a request is taken only while no earlier request is still being worked;
//   the result register lets a new request enter while a result waits.
//   malformed and trivial requests answer without touching the table. a
//   counted request makes one clear write per entry, then one table
//   update per cycle, bound by the single write port of the work table.
//   the update issue forwards the last write, so there is no interlock
//   bubble.
//   reset (rst_n, async, active low) drops any request in flight and empties
//   the result register; the table needs no clearing pass.
//   if m_axis stalls, the finished result stays put; one further request may
//   be worked, but no more is taken until its result moves into the result register.
// ----------------------------------------------------------------------------
module integer_partition_count_top
    import icp_pkg::*;
#(
    parameter int MAX_TOTAL = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // total, largest_part, zero fill
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // ways, zero fill
    output logic                       m_axis_tuser   // bad_query
);

    localparam int DEPTH = MAX_TOTAL + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [FIELD_W-1:0] total;
    logic [FIELD_W-1:0] largest_part;
    logic               accept;
    logic               out_of_range;
    logic               immediate;
    logic [WAYS_W-1:0]  imm_ways;
    logic               imm_bad;
    logic               res_avail;
    logic               load_out;

    logic              run_reg;
    logic              imm_reg;
    logic [WAYS_W-1:0] imm_ways_reg;
    logic              imm_bad_reg;
    logic              out_vld_reg;
    logic [WAYS_W-1:0] out_ways_reg;
    logic              out_bad_reg;

    icp_cmd_t cmd;
    icp_rsp_t rsp;
    logic     ack;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [WAYS_W-1:0] wdata;
    logic [AW-1:0]     ra_hi;
    logic [AW-1:0]     ra_lo;
    logic [WAYS_W-1:0] rd_hi;
    logic [WAYS_W-1:0] rd_lo;

    assign total        = s_axis_tdata[FIELD_W-1:0];
    assign largest_part = s_axis_tdata[2*FIELD_W-1:FIELD_W];

    assign s_axis_tready = !run_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // requests that never touch the table
    always_comb
    begin
        out_of_range = (total == '0) || (total > FIELD_W'(MAX_TOTAL));
        immediate    = out_of_range || (largest_part == '0);
        imm_bad      = out_of_range || (total != FIELD_W'(1));
        imm_ways     = imm_bad ? '0 : WAYS_W'(1);
    end

    always_comb
    begin
        cmd.start = accept && !immediate;
        cmd.total = total;
        cmd.part  = (largest_part > total) ? total : largest_part;
    end

    assign res_avail = run_reg && (imm_reg || rsp.done);
    assign load_out  = res_avail && (!out_vld_reg || m_axis_tready);
    assign ack       = load_out && !imm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                run_reg <= 1'b1;
            end
            else if (load_out)
            begin
                run_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            imm_reg      <= immediate;
            imm_ways_reg <= imm_ways;
            imm_bad_reg  <= imm_bad;
        end
        if (load_out)
        begin
            out_ways_reg <= imm_reg ? imm_ways_reg : rsp.ways;
            out_bad_reg  <= imm_reg && imm_bad_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-WAYS_W){1'b0}}, out_ways_reg};
    assign m_axis_tuser  = out_bad_reg;

    icp_engine #(
        .AW        (AW)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ack   (ack),
        .rsp   (rsp),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .ra_hi (ra_hi),
        .ra_lo (ra_lo),
        .rd_hi (rd_hi),
        .rd_lo (rd_lo)
    );

    icp_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .ra_hi (ra_hi),
        .ra_lo (ra_lo),
        .rd_hi (rd_hi),
        .rd_lo (rd_lo)
    );

endmodule

`default_nettype wire

[dv/integer_partition_count_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_partition_count_top_tb
// Drives partition-count requests into the block and checks every answer
// against a table-based count kept in the bench. Directed corner requests
// come first, then a random mix weighted toward small totals, with bursty
// input, a stalling output, and one long output hold-off.
// ----------------------------------------------------------------------------
module integer_partition_count_top_tb;
    import icp_pkg::*;

    localparam int MAX_TOTAL    = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 258;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 2300;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic [WAYS_W-1:0] ways;
        logic              bad;
    } answer_t;

    // keeps the work table and the answers still owed by the block
    class partition_ledger;
        logic [WAYS_W-1:0] work_row [0:MAX_TOTAL];
        answer_t           owed_answers[$];
        int unsigned       mismatches = 0;

        function void note_query(logic [FIELD_W-1:0] total, logic [FIELD_W-1:0] part);
            answer_t         a;
            int              clipped;
            logic [WAYS_W:0] sum;
            a.ways = '0;
            a.bad  = 1'b0;
            if (total == 0 || total > MAX_TOTAL) begin
                a.bad = 1'b1;
            end
            else if (part == 0) begin
                // a total of one still has its single partition
                if (total == 1)
                    a.ways = 1;
                else
                    a.bad = 1'b1;
            end
            else begin
                clipped = (part > total) ? total : part;
                work_row[0] = 1;
                for (int s = 1; s <= total; s++)
                    work_row[s] = '0;
                for (int k = 1; k <= clipped; k++) begin
                    for (int s = k; s <= total; s++) begin
                        sum = work_row[s] + work_row[s-k];
                        work_row[s] = (sum > WAYS_MAX) ? WAYS_MAX : sum[WAYS_W-1:0];
                    end
                end
                a.ways = work_row[total];
            end
            owed_answers.push_back(a);
        endfunction

        function void check_answer(logic [WAYS_W-1:0] ways, logic bad);
            answer_t a;
            if (owed_answers.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual ways=%0d bad_query=%0b",
                         $time, ways, bad);
                mismatches++;
            end
            else begin
                a = owed_answers.pop_front();
                if (ways !== a.ways) begin
                    $display("%0t: ways mismatch: expected %0d, actual %0d",
                             $time, a.ways, ways);
                    mismatches++;
                end
                if (bad !== a.bad) begin
                    $display("%0t: bad_query mismatch: expected %0b, actual %0b",
                             $time, a.bad, bad);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // total, largest_part, zero fill
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // ways, zero fill
    logic                  m_axis_tuser;        // bad_query

    partition_ledger ledger = new();

    int unsigned cycle_count  = 0;
    int unsigned answers_seen = 0;
    logic        hold_off     = 1'b0;
    int          burst_left   = 0;
    bit          calm         = 1'b0;
    int          rx_mode      = 0;
    int          rx_mode_left = 0;
    int          rx_stall     = 0;
    logic        rx_ready;

    integer_partition_count_top #(
        .MAX_TOTAL(MAX_TOTAL)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offers one request, with a random gap whenever a burst runs out
    task automatic offer_query(input logic [FIELD_W-1:0] total,
                               input logic [FIELD_W-1:0] part);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = calm ? 0 : $urandom_range(0, 25);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-2*FIELD_W){1'b0}}, part, total};
        do @(posedge clk); while (!s_axis_tready);
        ledger.note_query(total, part);
    endtask

    // result side: check accepted answers, then pick the next ready
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready) begin
            ledger.check_answer(m_axis_tdata[WAYS_W-1:0], m_axis_tuser);
            answers_seen <= answers_seen + 1;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 2000);
        end
        else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: rx_ready = 1'b1;
            1: rx_ready = ($urandom_range(0, 9) < 7);
            default: begin
                if (rx_stall > 0)
                    rx_stall--;
                else if ($urandom_range(0, 19) == 0)
                    rx_stall = $urandom_range(1, 200);
                rx_ready = (rx_stall == 0);
            end
        endcase
        m_axis_tready <= hold_off ? 1'b0 : rx_ready;
    end

    // one long output hold-off so the block backs up into its input
    initial
    begin
        while (answers_seen < 30) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [FIELD_W-1:0] dir_total [22] = '{0, 0, 1, 2, 1, 1, 64, 64, 64, 65, 127,
                                               127, 5, 5, 10, 64, 63, 2, 3, 100, 1, 42};
        logic [FIELD_W-1:0] dir_part  [22] = '{0, 5, 0, 0, 1, 127, 64, 1, 0, 3, 127,
                                               0, 3, 127, 10, 32, 63, 2, 2, 1, 64, 85};
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] part;
        int                 pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_total[i])
            offer_query(dir_total[i], dir_part[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 120 && i < 170);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                total = FIELD_W'($urandom_range(1, 16));
                part  = FIELD_W'($urandom_range(0, total + 3));
            end
            else if (pick < 75) begin
                total = FIELD_W'($urandom_range(17, 40));
                part  = FIELD_W'($urandom_range(0, 127));
            end
            else if (pick < 80) begin
                total = FIELD_W'($urandom_range(41, MAX_TOTAL));
                part  = FIELD_W'($urandom_range(0, 127));
            end
            else if (pick < 90) begin
                // malformed: zero or outside the table
                total = ($urandom_range(0, 3) == 0) ? '0 :
                        FIELD_W'($urandom_range(MAX_TOTAL + 1, 127));
                part  = FIELD_W'($urandom_range(0, 127));
            end
            else begin
                total = FIELD_W'($urandom_range(1, 8));
                part  = '0;
            end
            offer_query(total, part);
        end
        s_axis_tvalid <= 1'b0;

        while (ledger.owed_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.owed_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[integer_partition_count_top.f]
rtl/icp_pkg.sv
rtl/icp_table.sv
rtl/icp_engine.sv
rtl/integer_partition_count_top.sv
dv/integer_partition_count_top_tb.sv
